// ----- hw/rtl/prc_pkg.sv -----
`timescale 1ns / 1ps

package prc_pkg;

    // Table geometry
    localparam int BINS      = 1024;
    localparam int TERMS     = 25;
    localparam int BIN_W     = $clog2(BINS);
    localparam int ROW_W     = $clog2(TERMS + 1);
    localparam int TAB_AW    = BIN_W + ROW_W;
    localparam int TAB_DEPTH = 2 ** TAB_AW;
    localparam int COEF_AW   = (TERMS > 1) ? $clog2(TERMS) : 1;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int BIDX_W = 10;
    localparam int TIDX_W = 5;
    localparam int TVAL_W = 18;
    localparam int COEF_W = 24;
    localparam int PIX_W  = 20;
    localparam int OUT_W  = 17;
    localparam int EXP_W  = 5;

    localparam logic [EXP_W-1:0] EXP_RESET = 5'd10;

    // Bin quantizer: bin = floor(pix * exp * BINS / (5 * 2^17))
    localparam int SCALE_W  = PIX_W + EXP_W;
    localparam int X2_W     = SCALE_W + BIN_W;
    localparam int QSHIFT   = 17;
    localparam int Y_W      = X2_W - QSHIFT;
    localparam int RECIP_W  = 20;
    localparam int RECIP_SH = 22;
    localparam int RECIP5   = ((2 ** RECIP_SH) + 4) / 5;
    localparam int QPROD_W  = Y_W + RECIP_W;

    // Accumulator, Q.32
    localparam int PROD_W = TVAL_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TERMS + 1) + 1;

    localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
    localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(64'sh1_0000_0000);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(32'sd32768);
    localparam logic [OUT_W-1:0]        OUT_ONE  = 17'd65536;

    // Item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TAB  = 2'd0,
        FUNC_COEF = 2'd1,
        FUNC_PIX  = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

endpackage

// ----- hw/rtl/prc_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read
module prc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/pca_response_curve_pixel_map_top.sv -----
// Table and coefficient writes: one item per cycle while idle. A pixel result
//   is registered after the shift, quantize, run, drain and finish states.
// A new pixel is taken only once the last result is registered; the run state
//   steps the one read port of each table copy through one basis term per cycle.
// Reset (synchronous, active low) clears control and sets exposure to 10;
//   the basis and coefficient memories are not cleared.
`timescale 1ns / 1ps

module pca_response_curve_pixel_map_top import prc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [4:0]   i_cfg_wdata,     // exposure_tenths
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bin_index[9:0], term_index[14:10], table_value[32:15], coef_value[56:33],
    // red_in[76:57], green_in[96:77], blue_in[116:97], zero pad
    input  logic [119:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,    // func[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // red_out[16:0], green_out[33:17], blue_out[50:34], zero pad
    output logic [55:0]  m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_QUANT,
        S_RUN,
        S_DRAIN,
        S_FIN
    } t_state;

    localparam logic [ROW_W-1:0] K_LAST = ROW_W'(TERMS);

    t_state r_state, n_state;
    logic   r_out_valid;
    logic [3*OUT_W-1:0] r_out_data, n_out_data;
    logic [EXP_W-1:0]   r_exposure;

    // Input unpack
    t_func              w_func;
    logic [BIDX_W-1:0]  w_bin;
    logic [TIDX_W-1:0]  w_term;
    logic [TVAL_W-1:0]  w_tval;
    logic [COEF_W-1:0]  w_coef;
    logic [PIX_W-1:0]   w_pix [3];
    logic               w_in_acc;

    assign w_func   = t_func'(s_axis_tuser[1:0]);
    assign w_bin    = s_axis_tdata[9:0];
    assign w_term   = s_axis_tdata[14:10];
    assign w_tval   = s_axis_tdata[32:15];
    assign w_coef   = s_axis_tdata[56:33];
    assign w_pix[0] = s_axis_tdata[76:57];
    assign w_pix[1] = s_axis_tdata[96:77];
    assign w_pix[2] = s_axis_tdata[116:97];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Memory write decode
    logic              w_tab_we, w_coef_we;
    logic [TAB_AW-1:0] w_tab_waddr;
    logic [COEF_AW-1:0] w_coef_waddr;

    assign w_tab_we = w_in_acc && (w_func == FUNC_TAB) && (32'(w_bin) < 32'(BINS))
                      && (32'(w_term) <= 32'(TERMS));
    assign w_coef_we = w_in_acc && (w_func == FUNC_COEF) && (w_term != '0)
                       && (32'(w_term) <= 32'(TERMS));
    assign w_tab_waddr  = {BIN_W'(w_bin), ROW_W'(w_term)};
    assign w_coef_waddr = COEF_AW'(w_term - 5'd1);

    // Datapath registers
    logic [SCALE_W-1:0]       r_x   [3];
    logic [Y_W-1:0]           r_y   [3];
    logic [BIN_W-1:0]         r_bin [3];
    logic [ROW_W-1:0]         r_k;
    logic                     r_rd_vld, r_rd_mean;
    logic                     r_prod_vld;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc  [3];

    // Memory read side
    logic               w_rd_en;
    logic [COEF_AW-1:0] w_coef_raddr;
    logic [COEF_W-1:0]  w_coef_q;
    logic [TVAL_W-1:0]  w_tab_q [3];

    assign w_rd_en      = (r_state == S_RUN);
    assign w_coef_raddr = (r_k == '0) ? '0 : COEF_AW'(r_k - 1'b1);

    prc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (TERMS)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_coef_we),
        .i_wr_addr (w_coef_waddr),
        .i_wr_data (w_coef),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_coef_raddr),
        .o_rd_data (w_coef_q)
    );

    // One table copy per channel, all written together
    for (genvar c = 0; c < 3; c++) begin : g_tab
        prc_ram #(
            .WIDTH (TVAL_W),
            .DEPTH (TAB_DEPTH)
        ) u_tab_ram (
            .i_clk     (i_clk),
            .i_wr_en   (w_tab_we),
            .i_wr_addr (w_tab_waddr),
            .i_wr_data (w_tval),
            .i_rd_en   (w_rd_en),
            .i_rd_addr ({r_bin[c], r_k}),
            .o_rd_data (w_tab_q[c])
        );
    end

    // Bin quantizer: divide by five through a reciprocal, then saturate
    logic [QPROD_W-1:0] w_qp [3];
    logic [Y_W-1:0]     w_q  [3];
    logic [BIN_W-1:0]   w_qsat [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_qp[c] = QPROD_W'(r_y[c]) * QPROD_W'(RECIP5);
            w_q[c]  = Y_W'(w_qp[c] >> RECIP_SH);
            if (w_q[c] > Y_W'(BINS - 1)) begin
                w_qsat[c] = BIN_W'(BINS - 1);
            end else begin
                w_qsat[c] = BIN_W'(w_q[c]);
            end
        end
    end

    // Clamp to [0, 1] and round to Q1.16
    function automatic logic [OUT_W-1:0] f_clamp(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = a + ACC_HALF;
        if (a <= ACC_ZERO) begin
            return '0;
        end else if (a >= ACC_ONE) begin
            return OUT_ONE;
        end else begin
            return t[16 +: OUT_W];
        end
    endfunction

    assign n_out_data = {f_clamp(r_acc[2]), f_clamp(r_acc[1]), f_clamp(r_acc[0])};

    // Datapath
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (w_in_acc) begin
                r_x[c] <= SCALE_W'(w_pix[c]) * SCALE_W'(r_exposure);
            end
            if (r_state == S_SHIFT) begin
                r_y[c] <= Y_W'((X2_W'(r_x[c]) * X2_W'(BINS)) >> QSHIFT);
            end
            if (r_state == S_QUANT) begin
                r_bin[c] <= w_qsat[c];
                r_acc[c] <= ACC_ZERO;
            end else if (r_prod_vld) begin
                r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
            end
            // mean enters as Q.32, eigenvector terms as eig * coef
            if (r_rd_mean) begin
                r_prod[c] <= $signed({{(PROD_W - TVAL_W - 16){w_tab_q[c][TVAL_W-1]}},
                                      w_tab_q[c], 16'd0});
            end else begin
                r_prod[c] <= $signed(w_tab_q[c]) * $signed(w_coef_q);
            end
        end
        if (r_state == S_QUANT) begin
            r_k <= '0;
        end else if (r_state == S_RUN && r_k != K_LAST) begin
            r_k <= r_k + 1'b1;
        end
        r_rd_mean <= (r_k == '0);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_func == FUNC_PIX) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: n_state = S_QUANT;
            S_QUANT: n_state = S_RUN;
            S_RUN: begin
                if (r_k == K_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_exposure  <= EXP_RESET;
            r_rd_vld    <= 1'b0;
            r_prod_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= w_rd_en;
            r_prod_vld <= r_rd_vld;
            if (i_cfg_we) begin
                r_exposure <= i_cfg_wdata;
            end
            if (r_state == S_FIN && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_out_data;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_data};

    // Checks
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= OUT_ONE) && (m_axis_tdata[33:17] <= OUT_ONE)
                          && (m_axis_tdata[50:34] <= OUT_ONE))
        else $error("result above one");

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (!r_rd_vld && !r_prod_vld))
        else $error("accumulator read before pipeline drained");

    a_term_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k <= K_LAST))
        else $error("term counter out of range");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_rd_vld && !r_prod_vld))
        else $error("item taken while term pipeline busy");

endmodule
